>>> design/bfiq_pkg.sv
// Package for the Bloom filter insert/query block.
// Holds the sizes, operation codes and the request/response types of the
// modulo unit. It depends on nothing else.
package bfiq_pkg;

  localparam int MAX_FILTER_BITS = 4096;
  localparam int MAX_PROBES      = 30;
  localparam int MIN_FILTER_BITS = 64;
  localparam int HASH_W          = 32;
  localparam int BIT_W           = 13;
  localparam int PROBE_W         = 8;
  localparam int LEFT_W          = 5;
  localparam int FILTER_DEPTH    = MAX_FILTER_BITS / 8;
  localparam int ADDR_W          = $clog2(FILTER_DEPTH);
  localparam int ROTATE_RIGHT    = 17;
  localparam int MOD_STEPS       = 4;
  localparam int MOD_CYCLES      = HASH_W / MOD_STEPS;
  localparam int MOD_CNT_W       = $clog2(MOD_CYCLES);

  localparam logic [BIT_W-1:0]   BIT_COUNT_RESET   = BIT_W'(1024);
  localparam logic [PROBE_W-1:0] PROBE_COUNT_RESET = PROBE_W'(6);

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_QUERY  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic CFG_BIT_COUNT   = 1'b0;
  localparam logic CFG_PROBE_COUNT = 1'b1;

  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] dividend;
    logic [BIT_W-1:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [BIT_W-1:0] rem;
  } mod_rsp_t;

endpackage

>>> design/bfiq_mod_unit.sv
// Iterative remainder unit: 32-bit hash modulo the filter bit count.
// Restoring reduction, four bits per cycle. Uses bfiq_pkg.
module bfiq_mod_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  bfiq_pkg::mod_req_t req,
  output bfiq_pkg::mod_rsp_t rsp
);

  logic                                   busy_r;
  logic [bfiq_pkg::MOD_CNT_W-1:0]         cnt_r;
  logic [bfiq_pkg::HASH_W-1:0]            dvd_r;
  logic [bfiq_pkg::BIT_W-1:0]             div_r;
  logic [bfiq_pkg::BIT_W-1:0]             acc_r;
  logic                                   done_r;
  logic [bfiq_pkg::BIT_W-1:0]             rem_r;
  logic [bfiq_pkg::BIT_W-1:0]             step_rem;
  logic [bfiq_pkg::HASH_W-1:0]            step_dvd;
  logic                                   last;

  // Four dependent shift, compare and subtract steps on 14-bit values.
  always_comb begin
    logic [bfiq_pkg::BIT_W:0]    acc;
    logic [bfiq_pkg::HASH_W-1:0] d;
    acc = {1'b0, acc_r};
    d   = dvd_r;
    for (int i = 0; i < bfiq_pkg::MOD_STEPS; i++) begin
      acc = {acc[bfiq_pkg::BIT_W-1:0], d[bfiq_pkg::HASH_W-1]};
      d   = {d[bfiq_pkg::HASH_W-2:0], 1'b0};
      if (acc >= {1'b0, div_r}) begin
        acc = acc - {1'b0, div_r};
      end
    end
    step_rem = acc[bfiq_pkg::BIT_W-1:0];
    step_dvd = d;
  end

  assign last = busy_r && (cnt_r == bfiq_pkg::MOD_CNT_W'(bfiq_pkg::MOD_CYCLES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= last;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      div_r <= req.divisor;
      acc_r <= '0;
    end else if (busy_r) begin
      dvd_r <= step_dvd;
      acc_r <= step_rem;
    end
    if (last) begin
      rem_r <= step_rem;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

>>> design/bloom_filter_insert_query.sv
// Bloom filter with double hashing: insert, query and clear of a 4096-bit array.
// Top level; uses bfiq_pkg and bfiq_mod_unit.
//
// Each input word carries an operation and the 32-bit hash of a key. Probe j of
// a key uses bit (h + j*delta) mod bits, where delta is the hash rotated right by
// 17 and bits is the configured count, raised to 64, rounded up to a multiple of
// eight and clamped to 4096. A shared remainder unit reduces the hash four bits a
// cycle; each probe passes through the remainder unit, then a step for its result
// and the registered read of the byte array, then a step to test or set the bit.
// An insert runs min(probe_count,30) probes; a query stops at the first clear bit,
// and a query with zero probes or more than 30 answers 1. A clear, and reset,
// sweep the 512-byte array one byte a cycle, and no word is taken during the sweep.
// Only queries give a result word; kind 3 is taken and ignored. The block works
// on one word at a time, but a finished answer waits in an output register, so
// the next word may be taken before it is collected. Configuration writes land
// at once and must only be made while the block is idle.
module bloom_filter_insert_query (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_kind,
  input  logic [bfiq_pkg::HASH_W-1:0]     in_key_hash,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_may_match,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [bfiq_pkg::BIT_W-1:0]      cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CLEAR = 5'b00010,
    S_MOD   = 5'b00100,
    S_UPD   = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [bfiq_pkg::ADDR_W-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [bfiq_pkg::HASH_W-1:0]     h_r, h_nxt;
  logic [bfiq_pkg::HASH_W-1:0]     delta_r, delta_nxt;
  logic [bfiq_pkg::BIT_W-1:0]      bits_r, bits_nxt;
  logic [bfiq_pkg::LEFT_W-1:0]     left_r, left_nxt;
  logic                            is_query_r, is_query_nxt;
  logic                            hit_r, hit_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_may_match_r, out_may_match_nxt;
  logic [bfiq_pkg::BIT_W-1:0]      fbc_r;
  logic [bfiq_pkg::PROBE_W-1:0]    pc_r;

  logic [7:0]                      mem [bfiq_pkg::FILTER_DEPTH];
  logic [7:0]                      rd_data_r;
  logic [bfiq_pkg::ADDR_W-1:0]     addr_r;
  logic [2:0]                      bsel_r;
  logic                            mem_we;
  logic [bfiq_pkg::ADDR_W-1:0]     mem_waddr;
  logic [7:0]                      mem_wdata;

  bfiq_pkg::mod_req_t              mod_req;
  bfiq_pkg::mod_rsp_t              mod_rsp;

  logic [bfiq_pkg::BIT_W-1:0]      bits_use;
  logic [bfiq_pkg::LEFT_W-1:0]     ins_probes;
  logic                            query_trivial;
  logic [bfiq_pkg::HASH_W-1:0]     in_delta;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fbc_r <= bfiq_pkg::BIT_COUNT_RESET;
      pc_r  <= bfiq_pkg::PROBE_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bfiq_pkg::CFG_BIT_COUNT:   fbc_r <= cfg_wdata;
        bfiq_pkg::CFG_PROBE_COUNT: pc_r  <= cfg_wdata[bfiq_pkg::PROBE_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective bit count: at least 64, rounded up to whole bytes, at most 4096.
  always_comb begin
    logic [bfiq_pkg::BIT_W:0] b;
    b = {1'b0, fbc_r};
    if (b < (bfiq_pkg::BIT_W+1)'(bfiq_pkg::MIN_FILTER_BITS)) begin
      b = (bfiq_pkg::BIT_W+1)'(bfiq_pkg::MIN_FILTER_BITS);
    end
    b = (b + (bfiq_pkg::BIT_W+1)'(7)) & ~(bfiq_pkg::BIT_W+1)'(7);
    if (b > (bfiq_pkg::BIT_W+1)'(bfiq_pkg::MAX_FILTER_BITS)) begin
      b = (bfiq_pkg::BIT_W+1)'(bfiq_pkg::MAX_FILTER_BITS);
    end
    bits_use = b[bfiq_pkg::BIT_W-1:0];
  end

  assign ins_probes = (pc_r > bfiq_pkg::PROBE_W'(bfiq_pkg::MAX_PROBES))
                    ? bfiq_pkg::LEFT_W'(bfiq_pkg::MAX_PROBES) : pc_r[bfiq_pkg::LEFT_W-1:0];
  assign query_trivial = (pc_r == '0) || (pc_r > bfiq_pkg::PROBE_W'(bfiq_pkg::MAX_PROBES));
  assign in_delta = {in_key_hash[bfiq_pkg::ROTATE_RIGHT-1:0],
                     in_key_hash[bfiq_pkg::HASH_W-1:bfiq_pkg::ROTATE_RIGHT]};

  always_comb begin
    state_nxt         = state_r;
    clr_cnt_nxt       = clr_cnt_r;
    h_nxt             = h_r;
    delta_nxt         = delta_r;
    bits_nxt          = bits_r;
    left_nxt          = left_r;
    is_query_nxt      = is_query_r;
    hit_nxt           = hit_r;
    out_valid_nxt     = out_valid_r;
    out_may_match_nxt = out_may_match_r;
    mem_we            = 1'b0;
    mem_waddr         = addr_r;
    mem_wdata         = rd_data_r | (8'd1 << bsel_r);
    in_ready          = (state_r == S_IDLE);
    mod_req.start     = 1'b0;
    mod_req.dividend  = (state_r == S_IDLE) ? in_key_hash : h_r + delta_r;
    mod_req.divisor   = (state_r == S_IDLE) ? bits_use : bits_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          h_nxt        = in_key_hash;
          delta_nxt    = in_delta;
          bits_nxt     = bits_use;
          hit_nxt      = 1'b1;
          unique case (in_kind)
            bfiq_pkg::KIND_INSERT: begin
              if (ins_probes != '0) begin
                left_nxt      = ins_probes;
                is_query_nxt  = 1'b0;
                mod_req.start = 1'b1;
                state_nxt     = S_MOD;
              end
            end
            bfiq_pkg::KIND_QUERY: begin
              if (query_trivial) begin
                state_nxt = S_RESP;
              end else begin
                left_nxt      = pc_r[bfiq_pkg::LEFT_W-1:0];
                is_query_nxt  = 1'b1;
                mod_req.start = 1'b1;
                state_nxt     = S_MOD;
              end
            end
            bfiq_pkg::KIND_CLEAR: begin
              clr_cnt_nxt = '0;
              state_nxt   = S_CLEAR;
            end
            default: ;
          endcase
        end
      end
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == bfiq_pkg::ADDR_W'(bfiq_pkg::FILTER_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_MOD: begin
        if (mod_rsp.done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (is_query_r && !rd_data_r[bsel_r]) begin
          hit_nxt   = 1'b0;
          state_nxt = S_RESP;
        end else begin
          mem_we   = !is_query_r;
          h_nxt    = h_r + delta_r;
          left_nxt = left_r - 1'b1;
          if (left_r == bfiq_pkg::LEFT_W'(1)) begin
            state_nxt = is_query_r ? S_RESP : S_IDLE;
          end else begin
            mod_req.start = 1'b1;
            state_nxt     = S_MOD;
          end
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt     = 1'b1;
          out_may_match_nxt = hit_r;
          state_nxt         = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r             <= h_nxt;
    delta_r         <= delta_nxt;
    bits_r          <= bits_nxt;
    left_r          <= left_nxt;
    is_query_r      <= is_query_nxt;
    hit_r           <= hit_nxt;
    out_may_match_r <= out_may_match_nxt;
  end

  // Filter byte array: one write port, one registered read port. The read is
  // taken when the remainder arrives; the bit position picks byte and bit.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state_r == S_MOD && mod_rsp.done) begin
      rd_data_r <= mem[mod_rsp.rem[bfiq_pkg::ADDR_W+2:3]];
      addr_r    <= mod_rsp.rem[bfiq_pkg::ADDR_W+2:3];
      bsel_r    <= mod_rsp.rem[2:0];
    end
  end

  bfiq_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  assign out_valid     = out_valid_r;
  assign out_may_match = out_may_match_r;

endmodule

>>> design/bfiq_checker.sv
// Port-level checks for the Bloom filter insert/query block.
// Bound to bloom_filter_insert_query; uses only its ports.
module bfiq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_kind,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_may_match
);

  // The array is swept after reset, so no word is taken straight away.
  a_reset_sweep: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("word taken during the clearing pass after reset");

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present after reset");

  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == bfiq_pkg::KIND_CLEAR |=> !in_ready)
    else $error("word taken while the filter is being cleared");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == bfiq_pkg::KIND_QUERY |=> !in_ready)
    else $error("word taken in the cycle after a query");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_may_match))
    else $error("stalled result word changed");

endmodule

bind bloom_filter_insert_query bfiq_checker u_bfiq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_kind       (in_kind),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_may_match (out_may_match)
);
